// File: rtl/csvtok_pkg.sv
// Shared constants, command encoding and whitespace classifier for the CSV
// field tokenizer. No dependencies.
`default_nettype none

package csvtok_pkg;

   localparam int DEFAULT_PENDING_DEPTH = 16;
   localparam int QUEUE_DEPTH           = 4;
   localparam int CHAR_W                = 16;

   localparam logic [CHAR_W-1:0] QUOTE_CHAR = 16'h0022;
   localparam logic [CHAR_W-1:0] COMMA_CHAR = 16'h002C;

   // command opcodes passed from front to back
   localparam logic [1:0] OP_NONE  = 2'd0;  // markers only
   localparam logic [1:0] OP_PUSH  = 2'd1;  // store interior whitespace
   localparam logic [1:0] OP_TEXT  = 2'd2;  // flush pending, emit char
   localparam logic [1:0] OP_COMMA = 2'd3;  // field end

   typedef struct packed {
      logic [1:0]        op;
      logic [CHAR_W-1:0] ch;
      logic              le;
      logic              drop;
   } cmd_type;

   function automatic logic is_ws(input logic [CHAR_W-1:0] c);
      logic r;
      r = (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D) ||
          (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
          (c >= 16'h2000 && c <= 16'h200A) ||
          (c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
          (c == 16'h205F) || (c == 16'h3000);
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/csvtok_front.sv
// Front end: accepts characters, tracks quoting and trim state, and issues
// commands to the queue. Depends on csvtok_pkg.
`default_nettype none

module csvtok_front
   import csvtok_pkg::*;
#(
   parameter int PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CHAR_W-1:0] char_code,
   input  wire logic              line_end,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              q_full,
   output logic                   push,
   output cmd_type                push_cmd
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   logic             quoted_ff, quoted_in;
   logic             qsq_ff, qsq_in;
   logic             text_ff, text_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   cmd_type          cmd;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      logic handled;
      handled   = 1'b0;
      quoted_in = quoted_ff;
      qsq_in    = qsq_ff;
      text_in   = text_ff;
      cnt_in    = cnt_ff;
      cmd.op    = OP_NONE;
      cmd.ch    = char_code;
      cmd.le    = line_end;
      cmd.drop  = 1'b0;

      if (qsq_ff) begin
         qsq_in = 1'b0;
         if (char_code == QUOTE_CHAR) begin
            cmd.op  = OP_TEXT;
            text_in = 1'b1;
            cnt_in  = '0;
            handled = 1'b1;
         end else begin
            quoted_in = 1'b0;
         end
      end

      if (!handled) begin
         if (char_code == QUOTE_CHAR) begin
            if (quoted_in) begin
               qsq_in = 1'b1;
            end else begin
               quoted_in = 1'b1;
            end
         end else if (char_code == COMMA_CHAR && !quoted_in) begin
            cmd.op  = OP_COMMA;
            text_in = 1'b0;
            cnt_in  = '0;
         end else if (is_ws(char_code)) begin
            if (text_ff) begin
               if (cnt_ff < CNT_W'(PENDING_DEPTH)) begin
                  cmd.op = OP_PUSH;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  cmd.drop = 1'b1;
               end
            end
         end else begin
            cmd.op  = OP_TEXT;
            text_in = 1'b1;
            cnt_in  = '0;
         end
      end

      if (line_end) begin
         quoted_in = 1'b0;
         qsq_in    = 1'b0;
         text_in   = 1'b0;
         cnt_in    = '0;
      end
   end

   assign push     = accept && (cmd.op != OP_NONE || cmd.le || cmd.drop);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         quoted_ff <= 1'b0;
         qsq_ff    <= 1'b0;
         text_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else if (accept) begin
         quoted_ff <= quoted_in;
         qsq_ff    <= qsq_in;
         text_ff   <= text_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/csvtok_queue.sv
// Short command queue decoupling front end and back end.
// Depends on csvtok_pkg.
`default_nettype none

module csvtok_queue
   import csvtok_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/csvtok_back.sv
// Back end: executes queued commands, holds the pending whitespace store and
// drives the registered result channel. Depends on csvtok_pkg.
`default_nettype none

module csvtok_back
   import csvtok_pkg::*;
#(
   parameter int PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire cmd_type           q_head,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [CHAR_W-1:0]      out_char,
   output logic                   char_valid,
   output logic                   field_end,
   output logic                   row_end,
   output logic                   space_overflow
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SPACE = 3'd1;
   localparam logic [2:0] S_CHAR  = 3'd2;
   localparam logic [2:0] S_FIELD = 3'd3;
   localparam logic [2:0] S_END   = 3'd4;

   logic [CHAR_W-1:0] pend_mem [PENDING_DEPTH];
   logic [CHAR_W-1:0] rd_q_ff;

   logic [2:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              we, re;
   logic [IDX_W-1:0]  rd_addr;

   logic              slot_free;
   logic              emit;
   logic [CHAR_W-1:0] e_char;
   logic              e_valid, e_fe, e_re, e_ov;

   logic              valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              cv_ff, fe_ff, re_ff, ov_ff;

   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      pop       = 1'b0;
      we        = 1'b0;
      re        = 1'b0;
      rd_addr   = rd_idx_ff[IDX_W-1:0];
      emit      = 1'b0;
      e_char    = '0;
      e_valid   = 1'b0;
      e_fe      = 1'b0;
      e_re      = 1'b0;
      e_ov      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_head;
               unique case (q_head.op)
                  OP_PUSH: begin
                     we       = 1'b1;
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = q_head.le ? S_END : S_IDLE;
                  end
                  OP_TEXT: begin
                     if (cnt_ff != '0) begin
                        re        = 1'b1;
                        rd_addr   = '0;
                        rd_idx_in = CNT_W'(1);
                        state_in  = S_SPACE;
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
                  OP_COMMA: state_in = S_FIELD;
                  default:  state_in = S_END;
               endcase
            end
         end
         S_SPACE: begin
            if (slot_free) begin
               emit    = 1'b1;
               e_char  = rd_q_ff;
               e_valid = 1'b1;
               if (rd_idx_ff == cnt_ff) begin
                  state_in = S_CHAR;
               end else begin
                  re        = 1'b1;
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
               end
            end
         end
         S_CHAR: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_char   = cmd_ff.ch;
               e_valid  = 1'b1;
               cnt_in   = '0;
               state_in = cmd_ff.le ? S_END : S_IDLE;
            end
         end
         S_FIELD: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_fe     = 1'b1;
               cnt_in   = '0;
               state_in = cmd_ff.le ? S_END : S_IDLE;
            end
         end
         S_END: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_fe     = cmd_ff.le;
               e_re     = cmd_ff.le;
               e_ov     = cmd_ff.drop;
               if (cmd_ff.le) begin
                  cnt_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         pend_mem[cnt_ff[IDX_W-1:0]] <= q_head.ch;
      end
      if (re) begin
         rd_q_ff <= pend_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_idx_ff <= rd_idx_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         char_ff <= e_char;
         cv_ff   <= e_valid;
         fe_ff   <= e_fe;
         re_ff   <= e_re;
         ov_ff   <= e_ov;
      end
   end

   assign out_valid      = valid_ff;
   assign out_char       = char_ff;
   assign char_valid     = cv_ff;
   assign field_end      = fe_ff;
   assign row_end        = re_ff;
   assign space_overflow = ov_ff;

endmodule

`default_nettype wire

// File: rtl/csv_line_field_tokenizer.sv
// Top level of the CSV line field tokenizer: front end, command queue and
// back end. Depends on csvtok_pkg, csvtok_front, csvtok_queue, csvtok_back.
//
//   channel  direction  tdata            tuser                          tlast
//   req      in         char_code[15:0]  -                              line_end
//   rsp      out        out_char[15:0]   char_valid, field_end, overflow row_end
//
// The front end takes one character per cycle while the four-entry command
// queue has room. The back-end sequencer pops a command in S_IDLE, then emits
// its results whenever the result slot is free (any flushed whitespace from
// S_SPACE before the character from S_CHAR) before it pops the next. Reset is
// synchronous and clears all control state; the pending store needs no
// clearing pass. A stalled rsp side fills the queue and then drops req_tready.
`default_nettype none

module csv_line_field_tokenizer
   import csvtok_pkg::*;
#(
   parameter int PENDING_DEPTH = DEFAULT_PENDING_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // char_code[15:0]
   input  wire logic        req_tlast,   // line_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_char[15:0]
   output logic [2:0]       rsp_tuser,   // char_valid, field_end, space_overflow
   output logic             rsp_tlast    // row_end
);

   logic    q_full, q_empty, push, pop;
   cmd_type push_cmd, q_head;
   logic    cv, fe, ov;

   csvtok_front #(
      .PENDING_DEPTH(PENDING_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .char_code (req_tdata),
      .line_end  (req_tlast),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   csvtok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   csvtok_back #(
      .PENDING_DEPTH(PENDING_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_char       (rsp_tdata),
      .char_valid     (cv),
      .field_end      (fe),
      .row_end        (rsp_tlast),
      .space_overflow (ov)
   );

   assign rsp_tuser = {ov, fe, cv};

endmodule

`default_nettype wire

// File: rtl/csvtok_checker.sv
// Port-level checks for the CSV line field tokenizer, bound to the top level.
// Depends on csv_line_field_tokenizer.
`default_nettype none

module csvtok_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_row_ends_field: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1] && !rsp_tuser[0])
      else $error("row end without field end marker");

   a_char_no_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && !rsp_tuser[2] && !rsp_tlast)
      else $error("character transaction carries a marker");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'h0000)
      else $error("marker transaction with nonzero data");

endmodule

bind csv_line_field_tokenizer csvtok_checker u_csvtok_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: tb/sv/tb_csv_line_field_tokenizer.sv
// Self-checking testbench for csv_line_field_tokenizer: streams CSV lines in, predicts
// the field tokens and markers, and checks every rsp transaction in order.
// Depends on csvtok_pkg and the csv_line_field_tokenizer RTL.
`default_nettype none

module tb_csv_line_field_tokenizer;
   import csvtok_pkg::*;

   localparam int PENDING_DEPTH = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic [15:0] code;
      logic        last;
   } char_item_type;

   typedef struct packed {
      logic [15:0] ch;
      logic        valid;
      logic        fend;
      logic        rend;
      logic        ovf;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   csv_line_field_tokenizer #(.PENDING_DEPTH(PENDING_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   char_item_type line_chars[$];
   token_type     expected_tokens[$];

   // tokenizer state mirror
   logic        in_quotes;
   logic        in_quote_pair;
   logic        field_started;
   logic [15:0] held_blanks[PENDING_DEPTH];
   int          held_count;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   int mismatches    = 0;
   int chars_taken   = 0;
   int tokens_seen   = 0;
   int field_ends    = 0;
   int overflow_seen = 0;
   int lines_queued  = 0;
   int input_stalls  = 0;

   function automatic logic is_blank(input logic [15:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
             c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
             c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
             c == 16'h3000;
   endfunction

   function automatic logic [15:0] blank_code(input int idx);
      case (idx)
         0:  return 16'h0009;
         1:  return 16'h000A;
         2:  return 16'h000B;
         3:  return 16'h000C;
         4:  return 16'h000D;
         5:  return 16'h0020;
         6:  return 16'h0085;
         7:  return 16'h00A0;
         8:  return 16'h1680;
         19: return 16'h2028;
         20: return 16'h2029;
         21: return 16'h202F;
         22: return 16'h205F;
         23: return 16'h3000;
         24: return 16'h200A;
         default: return 16'h2000 + 16'(idx - 9);
      endcase
   endfunction

   function automatic logic [15:0] pick_blank();
      return blank_code($urandom_range(0, 24));
   endfunction

   // text character: never blank, quote or comma
   function automatic logic [15:0] pick_text();
      logic [15:0] c;
      do begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: c = 16'($urandom_range(16'h21, 16'h7E));
            6: begin
               case ($urandom_range(0, 13))
                  0:  c = 16'h0000;
                  1:  c = 16'h0008;
                  2:  c = 16'h000E;
                  3:  c = 16'h001F;
                  4:  c = 16'h0084;
                  5:  c = 16'h0086;
                  6:  c = 16'h009F;
                  7:  c = 16'h00A1;
                  8:  c = 16'h1FFF;
                  9:  c = 16'h200B;
                  10: c = 16'h2027;
                  11: c = 16'h202A;
                  12: c = 16'h3001;
                  default: c = 16'hFFFF;
               endcase
            end
            default: c = 16'($urandom());
         endcase
      end while (is_blank(c) || c == QUOTE_CHAR || c == COMMA_CHAR);
      return c;
   endfunction

   function automatic logic [15:0] pick_noise();
      case ($urandom_range(0, 9))
         0, 1:    return QUOTE_CHAR;
         2, 3:    return COMMA_CHAR;
         4, 5:    return pick_blank();
         6:       return 16'($urandom());
         default: return pick_text();
      endcase
   endfunction

   function automatic void push_token(input logic [15:0] ch, input logic valid,
                                      input logic fend, input logic rend, input logic ovf);
      token_type t;
      t.ch = ch;
      t.valid = valid;
      t.fend = fend;
      t.rend = rend;
      t.ovf = ovf;
      expected_tokens.push_back(t);
   endfunction

   function automatic void emit_text(input logic [15:0] ch);
      for (int k = 0; k < held_count; k++) push_token(held_blanks[k], 1'b1, 1'b0, 1'b0, 1'b0);
      held_count = 0;
      field_started = 1'b1;
      push_token(ch, 1'b1, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic void clear_line_state();
      in_quotes = 1'b0;
      in_quote_pair = 1'b0;
      field_started = 1'b0;
      held_count = 0;
   endfunction

   function automatic void tokenize_char(input logic [15:0] code, input logic last);
      logic drop;
      logic done;
      drop = 1'b0;
      done = 1'b0;
      if (in_quote_pair) begin
         in_quote_pair = 1'b0;
         if (code == QUOTE_CHAR) begin
            emit_text(QUOTE_CHAR);
            done = 1'b1;
         end else begin
            in_quotes = 1'b0;
         end
      end
      if (!done) begin
         if (code == QUOTE_CHAR) begin
            if (in_quotes) in_quote_pair = 1'b1;
            else in_quotes = 1'b1;
         end else if (code == COMMA_CHAR && !in_quotes) begin
            push_token('0, 1'b0, 1'b1, 1'b0, 1'b0);
            field_started = 1'b0;
            held_count = 0;
         end else if (is_blank(code)) begin
            if (field_started) begin
               if (held_count < PENDING_DEPTH) begin
                  held_blanks[held_count] = code;
                  held_count++;
               end else begin
                  drop = 1'b1;
               end
            end
         end else begin
            emit_text(code);
         end
      end
      if (last) begin
         push_token('0, 1'b0, 1'b1, 1'b1, drop);
         clear_line_state();
      end else if (drop) begin
         push_token('0, 1'b0, 1'b0, 1'b0, 1'b1);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      char_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         clear_line_state();
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_char(req_tdata, req_tlast);
            chars_taken++;
         end
         if (req_tvalid && !req_tready) input_stalls++;
         if (!req_tvalid || req_tready) begin
            if (line_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = line_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.code;
               req_tlast <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ch = rsp_tdata;
            got.valid = rsp_tuser[0];
            got.fend = rsp_tuser[1];
            got.ovf = rsp_tuser[2];
            got.rend = rsp_tlast;
            tokens_seen++;
            if (got.fend) field_ends++;
            if (got.ovf) overflow_seen++;
            if (expected_tokens.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp: char=%h valid=%b fend=%b rend=%b ovf=%b",
                           got.ch, got.valid, got.fend, got.rend, got.ovf);
            end else begin
               want = expected_tokens.pop_front();
               if (got.ch !== want.ch || got.valid !== want.valid || got.fend !== want.fend ||
                   got.rend !== want.rend || got.ovf !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch: exp char=%h valid=%b fend=%b rend=%b ovf=%b, %s",
                              want.ch, want.valid, want.fend, want.rend, want.ovf,
                              $sformatf("got char=%h valid=%b fend=%b rend=%b ovf=%b",
                                        got.ch, got.valid, got.fend, got.rend, got.ovf));
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic add_char(input logic [15:0] code, input logic last);
      char_item_type it;
      it.code = code;
      it.last = last;
      line_chars.push_back(it);
      if (last) lines_queued++;
   endtask

   task automatic add_line(ref logic [15:0] codes[$]);
      if (codes.size() == 0) codes.push_back(pick_text());
      foreach (codes[i]) add_char(codes[i], i == codes.size() - 1);
   endtask

   task automatic build_line(output int count);
      logic [15:0] codes[$];
      int nfields;
      int kind;
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) codes.push_back(COMMA_CHAR);
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            repeat ($urandom_range(1, 6)) codes.push_back(pick_noise());
         end else begin
            repeat ($urandom_range(0, 2)) codes.push_back(pick_blank());
            if (kind < 45) begin
               codes.push_back(QUOTE_CHAR);
               repeat ($urandom_range(0, 6)) begin
                  case ($urandom_range(0, 5))
                     0: codes.push_back(pick_blank());
                     1: codes.push_back(COMMA_CHAR);
                     2: begin
                        codes.push_back(QUOTE_CHAR);
                        codes.push_back(QUOTE_CHAR);
                     end
                     default: codes.push_back(pick_text());
                  endcase
               end
               if ($urandom_range(0, 19) != 0) codes.push_back(QUOTE_CHAR);
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 11) == 0)
                     repeat ($urandom_range(15, 19)) codes.push_back(pick_blank());
                  else
                     repeat ($urandom_range(1, 3)) codes.push_back(pick_blank());
                  repeat ($urandom_range(1, 4)) codes.push_back(pick_text());
               end
            end
            repeat ($urandom_range(0, 2)) codes.push_back(pick_blank());
         end
      end
      add_line(codes);
      count = codes.size();
   endtask

   task automatic queue_lines(input int target);
      int added;
      int n;
      added = 0;
      while (added < target) begin
         build_line(n);
         added += n;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (line_chars.size() != 0 || req_tvalid || expected_tokens.size() != 0);
   endtask

   initial begin
      logic [15:0] codes[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 83;
      // interior whitespace overflow, mid-line and at line end
      add_char(16'h0071, 1'b0);
      for (int k = 0; k < 17; k++) add_char(blank_code(k), 1'b0);
      add_char(16'h3000, 1'b1);
      // comma inside quotes, closing quote at line end
      codes = '{QUOTE_CHAR, COMMA_CHAR, QUOTE_CHAR};
      add_line(codes);
      // leading blank dropped, empty fields
      codes = '{16'h0020, COMMA_CHAR};
      add_line(codes);
      // doubled quote, then a quote closed by a non-quote
      codes = '{QUOTE_CHAR, 16'h0000, QUOTE_CHAR, QUOTE_CHAR, QUOTE_CHAR, 16'hFFFF};
      add_line(codes);
      // unterminated quote
      codes = '{QUOTE_CHAR};
      add_line(codes);
      queue_lines(120);
      wait_drained();

      send_idle_pct = 83;
      recv_idle_pct = 20;
      queue_lines(120);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_lines(60);
      hold_requests++;
      wait_drained();
      queue_lines(60);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_tokens.size() != 0) mismatches++;
      $display("covered %0d lines, %0d chars, %0d results (%0d field ends, %0d overflow flags)",
               lines_queued, chars_taken, tokens_seen, field_ends, overflow_seen);
      $display("req side stalled %0d cycles, %0d mismatches", input_stalls, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/csvtok_pkg.sv
rtl/csvtok_front.sv
rtl/csvtok_queue.sv
rtl/csvtok_back.sv
rtl/csv_line_field_tokenizer.sv
rtl/csvtok_checker.sv
tb/sv/tb_csv_line_field_tokenizer.sv
